### rtl/smhu_pkg.sv
// shared types and constants for the sos metropolis height update block
`default_nettype none

package smhu_pkg;

  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned BETA_W   = 16;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned DRAW_W   = 16;
  localparam int unsigned SITE_W   = 8;

  // energy change in q.12, signed
  localparam int unsigned DE_W     = 24;
  // exponent argument n in q4.8
  localparam int unsigned EXP_BITS = 12;
  localparam int unsigned EXP_K_W  = 4;
  localparam int unsigned PROB_W   = 17;

  // register file
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;
  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_FIELD = 2'd2;

  localparam logic [HEIGHT_W-1:0] LIMIT_RESET  = 8'd100;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 8'd50;
  localparam logic [BETA_W-1:0]   BETA_RESET   = 16'd256;
  localparam logic [FIELD_W-1:0]  FIELD_RESET  = 16'd0;

  // exp(-1/256) in q0.32
  localparam logic [31:0] EXP_STEP = 32'd4278222805;
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

  typedef logic [31:0] exp_tab_t [EXP_BITS];

  // c^(2^k) with each square rounded to nearest, worked out at elaboration
  function automatic exp_tab_t exp_tab_f();
    logic [63:0] b;
    exp_tab_t    t;
    b = {32'd0, EXP_STEP};
    for (int k = 0; k < EXP_BITS; k++) begin
      t[k] = b[31:0];
      b = (b * b + HALF_Q32) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_BASE = exp_tab_f();

  typedef struct packed {
    logic                start;
    logic [EXP_BITS-1:0] n;
  } decay_req_t;

  typedef struct packed {
    logic              done;
    logic [PROB_W-1:0] prob;
  } decay_rsp_t;

endpackage

`default_nettype wire

### rtl/smhu_decay.sv
// iterative exp(-n/256) unit, one bit of n per cycle, q1.16 result
`default_nettype none

module smhu_decay (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire smhu_pkg::decay_req_t req_i,
  output smhu_pkg::decay_rsp_t     rsp_o
);

  localparam logic [smhu_pkg::EXP_K_W-1:0] K_LAST =
    smhu_pkg::EXP_K_W'(smhu_pkg::EXP_BITS - 1);

  logic                              busy_q;
  logic                              done_q;
  logic [smhu_pkg::EXP_K_W-1:0]      k_q;
  logic [smhu_pkg::EXP_BITS-1:0]     n_q;
  logic [31:0]                       acc_q;
  logic                              one_q;
  logic [63:0]                       prod;
  logic [32:0]                       rounded;

  assign prod    = {32'd0, acc_q} * {32'd0, smhu_pkg::EXP_BASE[k_q]} + smhu_pkg::HALF_Q32;
  assign rounded = {1'b0, acc_q} + 33'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && k_q == K_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q   <= req_i.n;
      k_q   <= '0;
      one_q <= 1'b1;
    end else if (busy_q) begin
      if (n_q[k_q]) begin
        // one times base is the base exactly
        acc_q <= one_q ? smhu_pkg::EXP_BASE[k_q] : prod[63:32];
        one_q <= 1'b0;
      end
      if (k_q != K_LAST) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prob = one_q ? smhu_pkg::PROB_W'(17'h10000) : rounded[32:16];

endmodule

`default_nettype wire

### rtl/sos_metropolis_height_update.sv
// top level: metropolis height update of a ring of column heights
`default_nettype none

// Metropolis step for a 1d solid-on-solid interface. The SITES column heights live
// in two mirrored single-read synchronous memories, so a column and its left
// neighbor are read in one cycle and the right neighbor in the next. After reset
// a clearing pass writes the reset height to every column, one per cycle, while
// in_stall_o stays high; register writes are taken throughout. A request skips
// the exponential unit when the move leaves the height range, does not raise the
// energy, or has an exponent argument too large for 12 bits (then it is rejected);
// otherwise the exponential unit does one 32x32 multiply per bit of the exponent
// argument and then hands back the acceptance probability. One request
// is in flight at a time; a finished result waits in the output register while the
// next request is taken.
module sos_metropolis_height_update #(
  parameter int unsigned SITES = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [smhu_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [smhu_pkg::PDATA_W-1:0]     pwdata,
  output logic      [smhu_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready,
  // proposals
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [smhu_pkg::SITE_W-1:0]      site_i,
  input  wire logic                             direction_i,
  input  wire logic [smhu_pkg::DRAW_W-1:0]      random_draw_i,
  // results
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  accepted_o,
  output logic      [smhu_pkg::HEIGHT_W-1:0]    new_height_o,
  output logic      [smhu_pkg::SUM_W-1:0]       height_sum_o
);

  localparam int unsigned IDX_W = $clog2(SITES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SITES - 1);
  localparam logic [smhu_pkg::SUM_W-1:0] SUM_RESET =
    smhu_pkg::SUM_W'((SITES * 50) % 65536);

  typedef logic [IDX_W-1:0] site_tab_t [256];

  // site index reduced modulo SITES, by counting
  function automatic site_tab_t site_tab_f();
    logic [IDX_W-1:0] r;
    site_tab_t        t;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      t[i] = r;
      r = (r == IDX_LAST) ? '0 : r + 1'b1;
    end
    return t;
  endfunction

  localparam site_tab_t SITE_MOD = site_tab_f();

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_SCALE,
    ST_EXP,
    ST_FINISH
  } state_e;

  state_e state_q;

  // configuration registers
  logic [smhu_pkg::HEIGHT_W-1:0] limit_q;
  logic [smhu_pkg::BETA_W-1:0]   beta_q;
  logic [smhu_pkg::FIELD_W-1:0]  field_q;
  logic                          cfg_we;

  // request context
  logic [IDX_W-1:0]              clr_q;
  logic [IDX_W-1:0]              x_q;
  logic [IDX_W-1:0]              xr_q;
  logic                          dir_q;
  logic [smhu_pkg::DRAW_W-1:0]   draw_q;
  logic [smhu_pkg::HEIGHT_W-1:0] h_q;
  logic [smhu_pkg::HEIGHT_W-1:0] hl_q;
  logic [smhu_pkg::HEIGHT_W-1:0] nh_q;
  logic                          range_ok_q;
  logic                          de_pos_q;
  logic [smhu_pkg::DE_W-2:0]     de_mag_q;
  logic                          n_big_q;
  logic [smhu_pkg::SUM_W-1:0]    sum_q;

  // output register
  logic                          out_valid_q;
  logic                          accepted_q;
  logic [smhu_pkg::HEIGHT_W-1:0] new_height_q;
  logic [smhu_pkg::SUM_W-1:0]    height_sum_q;

  // memories
  logic [smhu_pkg::HEIGHT_W-1:0] mem_a [SITES];
  logic [smhu_pkg::HEIGHT_W-1:0] mem_b [SITES];
  logic [smhu_pkg::HEIGHT_W-1:0] rdata_a_q;
  logic [smhu_pkg::HEIGHT_W-1:0] rdata_b_q;
  logic [IDX_W-1:0]              ra_a;
  logic [IDX_W-1:0]              ra_b;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_wa;
  logic [smhu_pkg::HEIGHT_W-1:0] mem_wd;

  // datapath
  logic                          in_take;
  logic [IDX_W-1:0]              x_in;
  logic [IDX_W-1:0]              xl_in;
  logic [IDX_W-1:0]              xr_in;
  logic [8:0]                    h_up;
  logic [8:0]                    h_dn;
  logic                          range_ok;
  logic signed [10:0]            slope;
  logic signed [11:0]            de_int;
  logic signed [16:0]            mu_dir;
  logic signed [smhu_pkg::DE_W-1:0] de;
  logic [38:0]                   arg;
  logic [26:0]                   n_full;
  logic                          need_exp;
  logic                          can_out;
  logic                          finish;
  logic                          decide;
  logic [smhu_pkg::SUM_W-1:0]    sum_next;

  smhu_pkg::decay_req_t          dreq;
  smhu_pkg::decay_rsp_t          drsp;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      smhu_pkg::REG_LIMIT: prdata = {24'd0, limit_q};
      smhu_pkg::REG_BETA:  prdata = {16'd0, beta_q};
      smhu_pkg::REG_FIELD: prdata = {16'd0, field_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= smhu_pkg::LIMIT_RESET;
      beta_q  <= smhu_pkg::BETA_RESET;
      field_q <= smhu_pkg::FIELD_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        smhu_pkg::REG_LIMIT: limit_q <= pwdata[7:0];
        smhu_pkg::REG_BETA:  beta_q  <= pwdata[15:0];
        smhu_pkg::REG_FIELD: field_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // ring neighbors of the incoming site
  assign in_take = in_valid_i && (state_q == ST_IDLE);
  assign x_in    = SITE_MOD[site_i];
  assign xl_in   = (x_in == '0) ? IDX_LAST : x_in - 1'b1;
  assign xr_in   = (x_in == IDX_LAST) ? '0 : x_in + 1'b1;

  // column and left neighbor read at accept, right neighbor in the cycle after
  assign ra_a = (state_q == ST_IDLE) ? x_in : xr_q;
  assign ra_b = xl_in;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_a[mem_wa] <= mem_wd;
      mem_b[mem_wa] <= mem_wd;
    end
    rdata_a_q <= mem_a[ra_a];
    rdata_b_q <= mem_b[ra_b];
  end

  // height range and energy change, rdata_a_q holds the right neighbor here
  assign h_up = {1'b0, h_q} + 9'd1;
  assign h_dn = {1'b0, h_q} - 9'd1;
  assign range_ok = dir_q ? (h_up < {1'b0, limit_q})
                          : ((h_q != '0) && (h_dn < {1'b0, limit_q}));
  assign slope  = $signed({2'b00, h_q, 1'b0}) - $signed({3'b000, hl_q})
                - $signed({3'b000, rdata_a_q});
  assign de_int = dir_q ? ($signed({slope, 1'b0}) + 12'sd2)
                        : (12'sd2 - $signed({slope, 1'b0}));
  assign mu_dir = dir_q ? $signed({field_q[15], field_q})
                        : -$signed({field_q[15], field_q});
  assign de     = $signed({de_int, 12'd0}) + $signed({{7{mu_dir[16]}}, mu_dir});

  // beta * dE rounded to q4.8
  assign arg      = {23'd0, beta_q} * {16'd0, de_mag_q} + 39'd2048;
  assign n_full   = arg[38:12];
  assign need_exp = range_ok_q && de_pos_q && (n_full[26:12] == '0);

  assign dreq.start = (state_q == ST_SCALE) && need_exp;
  assign dreq.n     = n_full[11:0];

  smhu_decay u_decay (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign decide   = range_ok_q
                 && (!de_pos_q || (!n_big_q && ({1'b0, draw_q} < drsp.prob)));
  assign can_out  = !out_valid_q || !out_stall_i;
  assign finish   = (state_q == ST_FINISH) && can_out;
  assign sum_next = decide ? (dir_q ? sum_q + 16'd1 : sum_q - 16'd1) : sum_q;

  assign mem_we = (state_q == ST_CLEAR) || (finish && decide);
  assign mem_wa = (state_q == ST_CLEAR) ? clr_q : x_q;
  assign mem_wd = (state_q == ST_CLEAR) ? smhu_pkg::HEIGHT_RESET : nh_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sum_q       <= SUM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IDX_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            state_q <= ST_READ;
          end
        end
        ST_READ:  state_q <= ST_CALC;
        ST_CALC:  state_q <= ST_SCALE;
        ST_SCALE: state_q <= need_exp ? ST_EXP : ST_FINISH;
        ST_EXP: begin
          if (drsp.done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (can_out) begin
            sum_q       <= sum_next;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q    <= x_in;
      xr_q   <= xr_in;
      dir_q  <= direction_i;
      draw_q <= random_draw_i;
    end
    if (state_q == ST_READ) begin
      h_q  <= rdata_a_q;
      hl_q <= rdata_b_q;
    end
    if (state_q == ST_CALC) begin
      range_ok_q <= range_ok;
      de_pos_q   <= !de[smhu_pkg::DE_W-1] && (de != '0);
      de_mag_q   <= de[smhu_pkg::DE_W-2:0];
      nh_q       <= dir_q ? h_up[7:0] : h_dn[7:0];
    end
    if (state_q == ST_SCALE) begin
      n_big_q <= (n_full[26:12] != '0);
    end
    if (finish) begin
      accepted_q   <= decide;
      new_height_q <= decide ? nh_q : h_q;
      height_sum_q <= sum_next;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign new_height_o = new_height_q;
  assign height_sum_o = height_sum_q;

endmodule

`default_nettype wire
